FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the filter's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKRF_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SKRF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/skrf_pkg.sv
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Types and fixed constants shared by the signal strength filter modules.
// ----------------------------------------------------------------------------
package skrf_pkg;

  // Field widths.
  localparam int MEAS_W  = 16;
  localparam int GAIN_W  = 17;
  localparam int VAR_W   = 17;
  localparam int NOISE_W = 16;

  // Serial operand widths: multiplicand and accumulator.
  localparam int MCAND_W = 18;
  localparam int ACC_W   = 19;
  localparam int PROD_W  = ACC_W + 1;

  // One bit per cycle over a 17-bit quotient or multiplier.
  localparam int STEPS  = 17;
  localparam int STEP_W = $clog2(STEPS);

  // APB port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_NOISE = 1'b0;

  // Reset values and fixed-point limits.
  localparam logic [VAR_W-1:0]         VAR_ONE   = 17'd65536;
  localparam logic [NOISE_W-1:0]       R_RESET   = 16'd655;
  localparam logic signed [MEAS_W-1:0] EST_RESET = 16'sd512;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOADM,
    ST_MUL,
    ST_WRITE
  } state_t;

  // Control to a serial arithmetic unit.
  typedef struct packed {
    logic load;
    logic run;
  } unit_ctl_t;

endpackage

FILE: rtl/core/skrf_serdiv.sv
// ----------------------------------------------------------------------------
// Serial gain divider
// Restoring divider giving floor(P * 65536 / S), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module skrf_serdiv (
  input  logic                          clk,
  input  skrf_pkg::unit_ctl_t           ctl,
  input  logic [skrf_pkg::VAR_W-1:0]    dividend,
  input  logic [skrf_pkg::VAR_W-1:0]    divisor,
  output logic [skrf_pkg::GAIN_W-1:0]   quotient
);
  import skrf_pkg::*;

  logic [VAR_W:0]    rem_r, rem_nxt;
  logic [VAR_W-1:0]  div_r;
  logic [GAIN_W-1:0] q_r, q_nxt;
  logic [VAR_W:0]    diff;
  logic              ge;

  // One trial subtraction per cycle; the remainder stays below twice the divisor.
  always_comb begin
    ge      = rem_r >= {1'b0, div_r};
    diff    = rem_r - {1'b0, div_r};
    rem_nxt = ge ? {diff[VAR_W-1:0], 1'b0} : {rem_r[VAR_W-1:0], 1'b0};
    q_nxt   = {q_r[GAIN_W-2:0], ge};
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem_r <= {1'b0, dividend};
      div_r <= divisor;
      q_r   <= '0;
    end else if (ctl.run) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quotient = q_r;

endmodule

FILE: rtl/core/skrf_sermul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add multiplier, one multiplier bit per cycle, giving product >>> 16.
// ----------------------------------------------------------------------------
module skrf_sermul (
  input  logic                                 clk,
  input  skrf_pkg::unit_ctl_t                  ctl,
  input  logic signed [skrf_pkg::MCAND_W-1:0]  mcand,
  input  logic [skrf_pkg::GAIN_W-1:0]          mplier,
  output logic signed [skrf_pkg::PROD_W-1:0]   prod_hi
);
  import skrf_pkg::*;

  logic signed [MCAND_W-1:0] m_r;
  logic [GAIN_W-1:0]         sh_r;
  logic signed [ACC_W-1:0]   hi_r;
  logic                      lsb_r;
  logic signed [ACC_W-1:0]   sum;

  // Add the multiplicand when the current multiplier bit is set.
  always_comb begin
    sum = hi_r + (sh_r[0] ? ACC_W'(m_r) : '0);
  end

  // Accumulator shifts right each step; the last bit out is product bit 16.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      m_r   <= mcand;
      sh_r  <= mplier;
      hi_r  <= '0;
      lsb_r <= 1'b0;
    end else if (ctl.run) begin
      hi_r  <= sum >>> 1;
      lsb_r <= sum[0];
      sh_r  <= sh_r >> 1;
    end
  end

  assign prod_hi = {hi_r, lsb_r};

endmodule

FILE: rtl/core/scalar_kalman_rssi_filter_unit.sv
// ----------------------------------------------------------------------------
// Scalar Kalman signal strength filter
// One-dimensional Kalman update of a Q8.8 dBm estimate and its variance.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Beat contents
// in_       input      in_valid / in_stall     measurement (Q8.8 signed)
// out_      output     out_valid / out_stall   estimate (Q8.8), gain (Q1.16)
// cfg       APB        psel/penable/pready     noise_variance at address 0
//
// Each beat passes through idle, where it is accepted, the divider steps for
// the gain, a load step, the steps of the two parallel serial multipliers,
// and the write state. The result is registered as the write state ends.
// A new beat is taken while the previous result waits on out_stall; the write
// cycle then repeats until that result leaves.
// Reset is synchronous: estimate 2.0 dBm, variance 1.0, R = 655.
// ----------------------------------------------------------------------------
module scalar_kalman_rssi_filter_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [skrf_pkg::MEAS_W-1:0]     in_measurement,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [skrf_pkg::MEAS_W-1:0]     out_estimate,
  output logic [skrf_pkg::GAIN_W-1:0]            out_gain,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [skrf_pkg::ADDR_W-1:0]            paddr,
  input  logic [skrf_pkg::DATA_W-1:0]            pwdata,
  output logic [skrf_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);
  import skrf_pkg::*;

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [NOISE_W-1:0] noise_r;
  logic signed [MEAS_W-1:0] est_r, z_r;
  logic [VAR_W-1:0] p_r;
  logic [GAIN_W-1:0] k_r;
  logic out_valid_r;
  logic signed [MEAS_W-1:0] out_est_r;
  logic [GAIN_W-1:0] out_gain_r;

  logic in_fire, out_free, last_step, reg_sel, sum_zero;
  logic [VAR_W-1:0] sum;
  logic [GAIN_W-1:0] quot, k;
  logic signed [GAIN_W-1:0] delta;
  logic signed [PROD_W-1:0] est_step, var_prod;
  logic signed [PROD_W:0] est_full;
  logic signed [MEAS_W-1:0] est_new;
  logic [VAR_W-1:0] var_new;
  unit_ctl_t div_ctl, mul_ctl;

  // Handshake and APB decode.
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_step = cnt_r == STEP_W'(STEPS - 1);
  assign reg_sel   = paddr[ADDR_W-1:2] == REG_NOISE;
  assign pready    = 1'b1;
  assign prdata    = reg_sel ? DATA_W'(noise_r) : '0;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_DIV;
      ST_DIV:   if (last_step) state_nxt = ST_LOADM;
      ST_LOADM: state_nxt = ST_MUL;
      ST_MUL:   if (last_step) state_nxt = ST_WRITE;
      ST_WRITE: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    div_ctl  = '0;
    mul_ctl  = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        div_ctl.load = in_valid;
      end
      ST_DIV:   div_ctl.run  = 1'b1;
      ST_LOADM: mul_ctl.load = 1'b1;
      ST_MUL:   mul_ctl.run  = 1'b1;
      ST_WRITE: in_stall     = 1'b1;
      default:  in_stall     = 1'b1;
    endcase
  end

  // Step counter for the serial phases.
  always_comb begin
    cnt_nxt = '0;
    if ((state_r == ST_DIV || state_r == ST_MUL) && !last_step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Gain: P + R fits 17 bits; a zero denominator forces the gain to zero.
  assign sum      = p_r + VAR_W'(noise_r);
  assign sum_zero = sum == '0;
  assign k        = sum_zero ? '0 : quot;
  assign delta    = GAIN_W'(z_r) - GAIN_W'(est_r);

  skrf_serdiv u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (p_r),
    .divisor  (sum),
    .quotient (quot)
  );

  // Estimate correction k * (z - est) >>> 16.
  skrf_sermul u_mul_est (
    .clk     (clk),
    .ctl     (mul_ctl),
    .mcand   (MCAND_W'(delta)),
    .mplier  (k),
    .prod_hi (est_step)
  );

  // Variance update (1 - k) * P >> 16.
  skrf_sermul u_mul_var (
    .clk     (clk),
    .ctl     (mul_ctl),
    .mcand   ($signed({1'b0, p_r})),
    .mplier  (GAIN_W'(VAR_ONE - k)),
    .prod_hi (var_prod)
  );

  // Final clamps, kept as guards.
  always_comb begin
    est_full = (PROD_W + 1)'(est_r) + (PROD_W + 1)'(est_step);
    if (est_full > (PROD_W + 1)'(32767)) begin
      est_new = 16'sh7fff;
    end else if (est_full < -(PROD_W + 1)'(32768)) begin
      est_new = 16'sh8000;
    end else begin
      est_new = est_full[MEAS_W-1:0];
    end
    if (var_prod[PROD_W-1]) begin
      var_new = '0;
    end else if (var_prod > PROD_W'(VAR_ONE)) begin
      var_new = VAR_ONE;
    end else begin
      var_new = var_prod[VAR_W-1:0];
    end
  end

  // Control and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      noise_r     <= R_RESET;
      est_r       <= EST_RESET;
      p_r         <= VAR_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (psel && penable && pwrite && reg_sel) begin
        noise_r <= pwdata[NOISE_W-1:0];
      end
      if (state_r == ST_WRITE && out_free) begin
        est_r       <= est_new;
        p_r         <= var_new;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      z_r <= in_measurement;
    end
    if (state_r == ST_LOADM) begin
      k_r <= k;
    end
    if (state_r == ST_WRITE && out_free) begin
      out_est_r  <= est_new;
      out_gain_r <= k_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_estimate = out_est_r;
  assign out_gain     = out_gain_r;

endmodule

FILE: rtl/core/skrf_checker.sv
// ----------------------------------------------------------------------------
// Filter port checker
// Port-level checks on the signal strength filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skrf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [skrf_pkg::MEAS_W-1:0]  out_estimate,
  input logic [skrf_pkg::GAIN_W-1:0]         out_gain
);
  import skrf_pkg::*;

  // A stalled result beat stays up.
  `SKRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // A stalled result beat keeps its payload.
  `SKRF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_estimate) && $stable(out_gain))

  // Once a measurement is taken the block is busy with it.
  `SKRF_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

  // The gain never exceeds 1.0.
  `SKRF_ASSERT_SAME(a_gain_range, clk, rst_n, out_valid, out_gain <= VAR_ONE)

endmodule

bind scalar_kalman_rssi_filter_unit skrf_checker u_skrf_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scalar Kalman signal strength filter testbench
// Drives measurements into the filter under several stall patterns and
// checks every estimate and gain beat against a fixed-point prediction kept
// in a small scoreboard. The noise variance register is rewritten between
// phases, with values ranging from its largest down to zero, and read back each time.
// ----------------------------------------------------------------------------
module testbench;
  import skrf_pkg::*;

  // Address of the noise variance register, and one that maps to no register.
  localparam logic [ADDR_W-1:0] NOISE_ADDR = ADDR_W'(4 * REG_NOISE);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 176;

  // Tracks the filter state and holds the expected result beats in order.
  class kalman_scoreboard;
    logic [NOISE_W-1:0]       noise_var;
    logic signed [MEAS_W-1:0] est;
    logic [VAR_W-1:0]         err_var;
    logic signed [MEAS_W-1:0] est_queue[$];
    logic [GAIN_W-1:0]        gain_queue[$];
    int                       errors;

    function new();
      noise_var = R_RESET;
      est       = EST_RESET;
      err_var   = VAR_ONE;
      errors    = 0;
    endfunction

    function void set_noise(logic [NOISE_W-1:0] r);
      noise_var = r;
    endfunction

    function int pending();
      return est_queue.size();
    endfunction

    // One Kalman update for an accepted measurement beat.
    function void note_meas(logic signed [MEAS_W-1:0] z);
      longint unsigned p, sum, k, pn;
      longint          diff, e;
      p    = err_var;
      sum  = p + noise_var;
      k    = 0;
      if (sum != 0) begin
        k = (p << 16) / sum;
        if (k > VAR_ONE) k = VAR_ONE;
      end
      // The shift of the signed product rounds toward minus infinity.
      diff = longint'(z) - longint'(est);
      e    = longint'(est) + ((longint'(k) * diff) >>> 16);
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
      est  = e[MEAS_W-1:0];
      pn   = ((64'd65536 - k) * p) >> 16;
      if (pn > VAR_ONE) pn = VAR_ONE;
      err_var = pn[VAR_W-1:0];
      est_queue.push_back(est);
      gain_queue.push_back(k[GAIN_W-1:0]);
    endfunction

    // Compares a result beat with the oldest expectation.
    function void check_result(logic signed [MEAS_W-1:0] got_est,
                               logic [GAIN_W-1:0] got_gain);
      logic signed [MEAS_W-1:0] want_est;
      logic [GAIN_W-1:0]        want_gain;
      if (est_queue.size() == 0) begin
        $display("%0t: unexpected result beat: estimate %0d gain %0d",
                 $time, got_est, got_gain);
        errors++;
        return;
      end
      want_est  = est_queue.pop_front();
      want_gain = gain_queue.pop_front();
      if (got_est !== want_est) begin
        $display("%0t: estimate mismatch: expected %0d, got %0d",
                 $time, want_est, got_est);
        errors++;
      end
      if (got_gain !== want_gain) begin
        $display("%0t: gain mismatch: expected %0d, got %0d",
                 $time, want_gain, got_gain);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [MEAS_W-1:0] in_measurement;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [MEAS_W-1:0] out_estimate;
  logic [GAIN_W-1:0]        out_gain;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  kalman_scoreboard sb = new();
  int  in_idle_pct  = 0;
  int  out_stall_pct = 0;
  bit  hold_out     = 1'b0;
  int  quiet_cycles = 0;

  scalar_kalman_rssi_filter_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_measurement (in_measurement),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_estimate   (out_estimate),
    .out_gain       (out_gain),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: random stall, or a long hold-off when one is running.
  always @(negedge clk) begin
    out_stall <= hold_out || ($urandom_range(0, 99) < out_stall_pct);
  end

  // Beat monitor and watchdog, sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_estimate, out_gain);
      if (in_valid && !in_stall) sb.note_meas(in_measurement);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Offers one measurement beat and returns at the falling edge after it
  // has been taken.
  task automatic send_meas(input logic signed [MEAS_W-1:0] z);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_measurement <= z;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every expected beat has come back, then lets the block settle.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One APB write; the bus is left idle afterwards.
  task automatic cfg_write(input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == NOISE_ADDR) sb.set_noise(data[NOISE_W-1:0]);
    @(negedge clk);
  endtask

  // Reads the noise variance back and compares it with the tracked value.
  task automatic cfg_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= NOISE_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[NOISE_W-1:0] !== sb.noise_var) begin
      $display("%0t: noise variance readback: expected %0d, got %0d",
               $time, sb.noise_var, prdata[NOISE_W-1:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_noise_var(input logic [NOISE_W-1:0] r);
    cfg_write(NOISE_ADDR, {{(DATA_W - NOISE_W){1'b0}}, r});
    cfg_check();
  endtask

  // Mostly full-range measurements, some close to the estimate, a few extremes.
  function automatic logic signed [MEAS_W-1:0] pick_meas();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return MEAS_W'($urandom);
    if (sel < 9) return sb.est + MEAS_W'($signed($urandom_range(0, 1024)) - 512);
    return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
                           input bit with_hold);
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    if (with_hold) begin
      fork
        begin
          hold_out = 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_out = 1'b0;
        end
      join_none
    end
    repeat (n) send_meas(pick_meas());
    end_burst();
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_measurement = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset value, then the largest noise variance for the directed beats.
    cfg_check();
    set_noise_var(16'hffff);
    send_meas(16'sh8000);
    send_meas(16'sh7fff);
    send_meas(16'sh0000);
    send_meas(-16'sd1);
    send_meas(16'sd1);
    send_meas(16'sh5555);
    send_meas(16'shaaaa);
    send_meas(16'sh7fff);
    send_meas(16'sh7fff);
    send_meas(-16'sd3);
    end_burst();
    drain();

    // A write to an unmapped address must leave the register alone.
    cfg_write(SPARE_ADDR, 32'h0000_0000);
    cfg_check();
    send_meas(16'sh8000);
    send_meas(16'sh0100);
    end_burst();
    drain();

    // Random phases under different idle and stall patterns.
    run_phase(PHASE_ITEMS, 0, 0, 1'b0);
    set_noise_var(16'(50000 + $urandom_range(0, 15535)));
    run_phase(PHASE_ITEMS, 69, 0, 1'b0);
    set_noise_var(16'(30000 + $urandom_range(0, 35535)));
    run_phase(PHASE_ITEMS, 0, 69, 1'b0);
    set_noise_var(16'hffff);
    run_phase(PHASE_ITEMS, 12, 12, 1'b0);
    set_noise_var(16'(40000 + $urandom_range(0, 25535)));
    run_phase(PHASE_ITEMS, 0, 0, 1'b1);

    // Back to the reset value, then zero noise: the first beat takes a gain
    // of one and empties the variance, after which the denominator is zero.
    in_idle_pct   = 0;
    out_stall_pct = 0;
    set_noise_var(R_RESET);
    send_meas(16'sh1234);
    send_meas(-16'sd2000);
    end_burst();
    drain();
    set_noise_var(16'h0000);
    send_meas(16'sh7fff);
    send_meas(16'sh8000);
    send_meas(16'sh0000);
    end_burst();
    drain();
    set_noise_var(16'h0001);
    send_meas(16'sh4000);
    end_burst();
    drain();

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
